FILE: sv/lwq_pkg.sv
// Package for the liveness window qualifier.
// Holds the item and result types, command and action codes and register indexes.
// No dependencies; every other file imports it.
package lwq_pkg;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Command codes of an input item.
  localparam logic [1:0] CMD_FRAME    = 2'd0;
  localparam logic [1:0] CMD_READY    = 2'd1;
  localparam logic [1:0] CMD_NO_FRAME = 2'd2;

  // Action codes of a result item.
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_FORWARD  = 2'd1;
  localparam logic [1:0] ACT_NO_FRAME = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ALIVE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOST  = 2'd3;

  // Register values after reset.
  localparam logic             RST_ENABLE    = 1'b1;
  localparam logic [CFG_W-1:0] RST_HIST_LEN  = 6'd11;
  localparam logic [CFG_W-1:0] RST_MIN_ALIVE = 6'd5;
  localparam logic [CFG_W-1:0] RST_MAX_LOST  = 6'd2;

  typedef struct packed {
    logic [1:0] command;
    logic       face_valid;
    logic       check_ok;
    logic       live;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       frame_done;
    logic       alive;
  } result_t;

  // Thresholds handed to the window judge.
  typedef struct packed {
    logic [CFG_W-1:0] min_alive;
    logic [CFG_W-1:0] max_lost;
  } judge_cfg_t;

endpackage

FILE: sv/liveness_window_qualifier_top.sv
// Top level of the liveness window qualifier: channels, configuration
// registers, verdict window, forwarding flags and the result register.
// Depends on lwq_pkg and lwq_judge.
//
//  Channel   Signals                            Direction  Transfer when
//  item      item_valid, item_stall, item       in         item_valid && !item_stall
//  result    result_valid, result_stall, result out        result_valid && !result_stall
//  config    cfg_valid, cfg_ready, cfg_index,   in         cfg_valid && cfg_ready
//            cfg_data
//
// An item that adds no verdict has its result ready for transfer in the cycle
// after its own transfer. An item that adds a verdict waits for the judge, which
// walks the window fill after the append (up to WINDOW_DEPTH entries) one entry per
// cycle. The next item can transfer in the cycle after the result transfer.
// Reset (rst, synchronous) empties the window, clears both forwarding flags and
// restores the register defaults. The block takes one item at a time: item_stall
// stays high from the transfer in until its result has been transferred out.
module liveness_window_qualifier_top #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  lwq_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output lwq_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lwq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lwq_pkg::CFG_W-1:0]        cfg_data
);
  import lwq_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_JUDGE = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;

  // Configuration registers. Writes are always taken.
  logic             enable;
  logic [CFG_W-1:0] hist_len;
  logic [CFG_W-1:0] min_alive;
  logic [CFG_W-1:0] max_lost;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= RST_ENABLE;
      hist_len  <= RST_HIST_LEN;
      min_alive <= RST_MIN_ALIVE;
      max_lost  <= RST_MAX_LOST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:    enable    <= cfg_data[0];
        REG_HIST_LEN:  hist_len  <= cfg_data;
        REG_MIN_ALIVE: min_alive <= cfg_data;
        REG_MAX_LOST:  max_lost  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and state.
  logic [1:0]              state;
  logic [WINDOW_DEPTH-1:0] window;
  logic [FILL_W-1:0]       fill;
  logic                    downstream_ready;
  logic                    data_pending;
  logic                    judge_start;
  logic                    judge_done;
  logic                    judge_alive;
  judge_cfg_t              judge_cfg;

  logic item_xfer;
  logic result_xfer;

  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_OUT);
  assign item_xfer    = item_valid && !item_stall;
  assign result_xfer  = result_valid && !result_stall;

  // The window is a shift line; entry 0 is the newest verdict.
  logic [WINDOW_DEPTH:0] shifted;
  logic [CMP_W-1:0]      cap;
  logic [CMP_W-1:0]      fill_inc;
  logic [FILL_W-1:0]     fill_next;

  assign shifted = {window, item.live};

  // Capacity is the history length minus one, floored at zero and capped at the depth.
  always_comb begin
    cap = (hist_len == '0) ? '0 : CMP_W'(hist_len) - CMP_W'(1);
    if (cap > CMP_W'(WINDOW_DEPTH)) begin
      cap = CMP_W'(WINDOW_DEPTH);
    end
    fill_inc = (CMP_W'(fill) < CMP_W'(WINDOW_DEPTH)) ? CMP_W'(fill) + CMP_W'(1)
                                                      : CMP_W'(fill);
    fill_next = (fill_inc > cap) ? FILL_W'(cap) : FILL_W'(fill_inc);
  end

  // Decode of an accepted item.
  logic       push;
  logic [1:0] action_next;
  logic       done_next;
  logic       ready_next;
  logic       pending_next;

  always_comb begin
    push         = 1'b0;
    action_next  = ACT_NONE;
    done_next    = 1'b0;
    ready_next   = downstream_ready;
    pending_next = data_pending;
    unique case (item.command)
      CMD_FRAME: begin
        done_next = 1'b1;
        if (!enable) begin
          action_next = ACT_FORWARD;
        end else if (item.face_valid) begin
          if (item.check_ok) begin
            push = 1'b1;
            if (downstream_ready) begin
              ready_next   = 1'b0;
              pending_next = 1'b0;
              action_next  = ACT_FORWARD;
            end else begin
              pending_next = 1'b1;
            end
          end else if (downstream_ready && data_pending) begin
            ready_next   = 1'b0;
            pending_next = 1'b0;
            action_next  = ACT_FORWARD;
          end else begin
            action_next = ACT_NO_FRAME;
          end
        end
      end
      CMD_READY:    ready_next  = 1'b1;
      CMD_NO_FRAME: action_next = ACT_NO_FRAME;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      window           <= '0;
      fill             <= '0;
      downstream_ready <= 1'b0;
      data_pending     <= 1'b0;
      judge_start      <= 1'b0;
    end else begin
      judge_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_xfer) begin
            downstream_ready <= ready_next;
            data_pending     <= pending_next;
            if (push) begin
              window      <= shifted[WINDOW_DEPTH-1:0];
              fill        <= fill_next;
              judge_start <= 1'b1;
              state       <= S_JUDGE;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_JUDGE: begin
          if (judge_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (result_xfer) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The result register is loaded on the item transfer; alive follows from the judge.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_xfer) begin
      result.action     <= action_next;
      result.frame_done <= done_next;
      result.alive      <= 1'b0;
    end else if (state == S_JUDGE && judge_done) begin
      result.alive <= judge_alive;
    end
  end

  assign judge_cfg.min_alive = min_alive;
  assign judge_cfg.max_lost  = max_lost;

  lwq_judge #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_judge (
    .clk    (clk),
    .rst    (rst),
    .start  (judge_start),
    .window (window),
    .fill   (fill),
    .cfg    (judge_cfg),
    .done   (judge_done),
    .alive  (judge_alive)
  );

  // The fill count never exceeds the window depth.
  assert property (@(posedge clk) disable iff (rst)
    CMP_W'(fill) <= CMP_W'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  // The judge only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    judge_done |-> (state == S_JUDGE))
    else $error("judge finished outside the judge phase");

  // A verdict can only be judged alive for a frame event.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.alive) |-> result.frame_done)
    else $error("alive set without a frame event");

  // A judge start always follows an item transfer that appended a verdict.
  assert property (@(posedge clk) disable iff (rst)
    judge_start |-> $past(item_xfer && push))
    else $error("judge started without an appended verdict");

  // Forwarding a frame while enabled always clears the downstream-ready flag.
  assert property (@(posedge clk) disable iff (rst)
    (item_xfer && item.command == CMD_FRAME && enable && action_next == ACT_FORWARD)
      |=> !downstream_ready)
    else $error("downstream ready left set after forwarding");

endmodule

FILE: sv/lwq_judge.sv
// Window judge of the liveness window qualifier: walks the verdict window
// from the oldest entry to the newest, one entry per cycle. Depends on lwq_pkg.
module lwq_judge #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [WINDOW_DEPTH-1:0]                       window,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]             fill,
  input  lwq_pkg::judge_cfg_t                           cfg,
  output logic                                          done,
  output logic                                          alive
);
  import lwq_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CMP_W  = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;

  localparam logic [1:0] J_IDLE   = 2'd0;
  localparam logic [1:0] J_WALK   = 2'd1;
  localparam logic [1:0] J_FINISH = 2'd2;

  logic [1:0]        state;
  logic [FILL_W-1:0] k;
  logic [FILL_W-1:0] live_count;
  logic [FILL_W-1:0] run;
  logic [FILL_W-1:0] worst;
  logic [IDX_W-1:0]  idx;
  logic              bit_live;

  assign idx      = IDX_W'(k - FILL_W'(1));
  assign bit_live = window[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= J_IDLE;
    end else begin
      unique case (state)
        J_IDLE: begin
          if (start) begin
            state <= J_WALK;
          end
        end
        J_WALK: begin
          if (k == '0) begin
            state <= J_FINISH;
          end
        end
        J_FINISH: state <= J_IDLE;
        default:  state <= J_IDLE;
      endcase
    end
  end

  // One entry per cycle: a live entry closes the current run of lost ones.
  always_ff @(posedge clk) begin
    if (state == J_IDLE) begin
      k          <= fill;
      live_count <= '0;
      run        <= '0;
      worst      <= '0;
    end else if (state == J_WALK && k != '0) begin
      k <= k - FILL_W'(1);
      if (bit_live) begin
        live_count <= live_count + FILL_W'(1);
        run        <= '0;
        if (run > worst) begin
          worst <= run;
        end
      end else begin
        run <= run + FILL_W'(1);
      end
    end
  end

  assign done  = (state == J_FINISH);
  assign alive = (CMP_W'(fill) >= CMP_W'(cfg.min_alive)) &&
                 (CMP_W'(live_count) >= CMP_W'(cfg.min_alive)) &&
                 (CMP_W'(worst) <= CMP_W'(cfg.max_lost));

endmodule

FILE: tb/sv/tb_liveness_window_qualifier_top.sv
// Self-checking testbench for liveness_window_qualifier_top: a directed burst, then
// random phases under changing register settings, with random gaps on both channels.
// Depends on lwq_pkg and the RTL of the block; reads nothing else.
module tb_liveness_window_qualifier_top;
  import lwq_pkg::*;

  // Tracks the block's window, forwarding flags and registers, works out the
  // decision that each accepted frame event must produce and checks the results.
  class liveness_tracker #(int DEPTH = 32);
    logic             enable;
    logic [CFG_W-1:0] hist_len;
    logic [CFG_W-1:0] min_alive;
    logic [CFG_W-1:0] max_lost;
    logic [DEPTH-1:0] window;  // bit 0 is the newest verdict
    int               fill;
    bit               downstream_ready;
    bit               data_pending;
    result_t          pending_decisions[$];
    int               mismatches;

    function new();
      enable           = RST_ENABLE;
      hist_len         = RST_HIST_LEN;
      min_alive        = RST_MIN_ALIVE;
      max_lost         = RST_MAX_LOST;
      window           = '0;
      fill             = 0;
      downstream_ready = 1'b0;
      data_pending     = 1'b0;
      mismatches       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ENABLE:    enable = data[0];
        REG_HIST_LEN:  hist_len = data;
        REG_MIN_ALIVE: min_alive = data;
        REG_MAX_LOST:  max_lost = data;
        default: ;
      endcase
    endfunction

    function void append_verdict(logic v);
      int cap;
      cap = (hist_len >= 1) ? int'(hist_len) - 1 : 0;
      if (cap > DEPTH) cap = DEPTH;
      window = {window[DEPTH-2:0], v};
      if (fill < DEPTH) fill++;
      if (fill > cap) fill = cap;
    endfunction

    // Walks the window from oldest to newest. A run of lost verdicts only
    // counts once a live verdict closes it.
    function logic window_alive();
      int live_count;
      int run;
      int worst;
      live_count = 0;
      run = 0;
      worst = 0;
      if (fill < int'(min_alive)) return 1'b0;
      for (int k = fill; k > 0; k--) begin
        if (window[k-1]) begin
          live_count++;
          if (run > worst) worst = run;
          run = 0;
        end else begin
          run++;
        end
      end
      return (live_count >= int'(min_alive) && worst <= int'(max_lost));
    endfunction

    function void note_frame_event(item_t it);
      result_t d;
      d = '0;
      case (it.command)
        CMD_FRAME: begin
          d.frame_done = 1'b1;
          if (!enable) begin
            d.action = ACT_FORWARD;
          end else if (it.face_valid) begin
            if (it.check_ok) begin
              append_verdict(it.live);
              d.alive = window_alive();
              if (downstream_ready) begin
                downstream_ready = 1'b0;
                data_pending = 1'b0;
                d.action = ACT_FORWARD;
              end else begin
                data_pending = 1'b1;
                d.action = ACT_NONE;
              end
            end else if (downstream_ready && data_pending) begin
              downstream_ready = 1'b0;
              data_pending = 1'b0;
              d.action = ACT_FORWARD;
            end else begin
              d.action = ACT_NO_FRAME;
            end
          end
        end
        CMD_READY:    downstream_ready = 1'b1;
        CMD_NO_FRAME: d.action = ACT_NO_FRAME;
        default: ;
      endcase
      pending_decisions.insert(pending_decisions.size(), d);
    endfunction

    function void check_decision(result_t got);
      result_t want;
      if (pending_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: action %0d frame_done %0d alive %0d",
                   got.action, got.frame_done, got.alive);
        return;
      end
      want = pending_decisions.pop_front();
      if (got.action !== want.action || got.frame_done !== want.frame_done ||
          got.alive !== want.alive) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected action %0d frame_done %0d alive %0d, got %0d %0d %0d",
                   want.action, want.frame_done, want.alive,
                   got.action, got.frame_done, got.alive);
      end
    endfunction

    function int failures();
      return mismatches + pending_decisions.size();
    endfunction
  endclass

  localparam int WINDOW_DEPTH = 32;
  // The command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // The limit lies well above the slowest correct run: about 1300 items, each at
  // worst the longest sender gap, a walk of the full window and the longest stall.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 90;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Switches for the idle behavior of each side; some phases run without it.
  bit in_gaps_on;
  bit out_stall_on;
  int stall_left;

  liveness_tracker #(WINDOW_DEPTH) tracker;

  liveness_window_qualifier_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t frame_event(logic [1:0] cmd, logic fv, logic ok, logic lv);
    item_t it;
    it.command = cmd;
    it.face_valid = fv;
    it.check_ok = ok;
    it.live = lv;
    return it;
  endfunction

  // Random stimulus is mostly frames with a face and a passed check, so the
  // window fills and the judge sees long histories; the rest is the other
  // commands, faceless frames and failed checks.
  function automatic item_t random_event(int live_pct);
    int r;
    item_t it;
    r = $urandom_range(0, 99);
    it = frame_event(CMD_FRAME, $urandom_range(0, 99) < 92, $urandom_range(0, 99) < 85,
                     $urandom_range(0, 99) < live_pct);
    if (r >= 95)      it = frame_event(CMD_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom));
    else if (r >= 84) it = frame_event(CMD_NO_FRAME, 1'($urandom), 1'($urandom), 1'($urandom));
    else if (r >= 70) it = frame_event(CMD_READY, 1'($urandom), 1'($urandom), 1'($urandom));
    return it;
  endfunction

  // The result side stalls in random bursts. Each falling edge assigns the
  // stall exactly once, so a running burst never glitches.
  initial begin
    result_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && out_stall_on && $urandom_range(0, 99) < 20)
        stall_left = idle_length();
      if (stall_left > 0) begin
        result_stall = 1'b1;
        stall_left--;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  // Every result transfer is checked against the oldest expected decision.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.check_decision(result);
  end

  // Offers one frame event, after an optional gap, and holds it until the
  // transfer happens. Valid stays high when the next event follows at once.
  task automatic offer_event(item_t it);
    int gap;
    gap = (in_gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
    repeat (gap) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    @(negedge clk);
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (!(item_valid && !item_stall));
    tracker.note_frame_event(it);
  endtask

  // Waits until every expected result has come back, then lets the block
  // settle so that register writes find it idle.
  task automatic wait_idle();
    while (tracker.pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  task automatic set_config(logic en, logic [CFG_W-1:0] hist, logic [CFG_W-1:0] min_live,
                            logic [CFG_W-1:0] lost);
    @(negedge clk);
    item_valid = 1'b0;
    wait_idle();
    write_reg(REG_ENABLE, {{(CFG_W-1){1'b0}}, en});
    write_reg(REG_HIST_LEN, hist);
    write_reg(REG_MIN_ALIVE, min_live);
    write_reg(REG_MAX_LOST, lost);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    item_t directed[$];
    logic             en;
    logic [CFG_W-1:0] hist;
    logic [CFG_W-1:0] min_live;
    logic [CFG_W-1:0] lost;
    int               live_pct;

    tracker = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    in_gaps_on = 1'b1;
    out_stall_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings (window of ten, five live needed,
    // at most two lost in a closed run).
    directed = '{
      frame_event(CMD_READY, 1'b0, 1'b0, 1'b0),      // downstream becomes ready
      frame_event(CMD_NO_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_UNUSED, 1'b1, 1'b1, 1'b1),     // must be ignored
      frame_event(CMD_FRAME, 1'b0, 1'b1, 1'b1),      // no face in the frame
      frame_event(CMD_FRAME, 1'b1, 1'b0, 1'b1),      // failed check, nothing pending
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),      // forwarded, flags cleared
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b0),      // held, data now pending
      frame_event(CMD_READY, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b0, 1'b0),      // failed check sends the held frame
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b0),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b0),      // trailing lost run
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),      // closes a run of two
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b0),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b0),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b0),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),      // closes a run of three
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),      // window full, oldest drop out
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1),
      frame_event(CMD_FRAME, 1'b1, 1'b1, 1'b1)
    };
    foreach (directed[i]) offer_event(directed[i]);

    // Random phases. The first ones pin the extreme settings: disabled,
    // a one-entry window, zero capacity from tiny sizes, the full window,
    // sizes past the window depth, and a sharp shrink of a full window.
    for (int p = 0; p < PHASES; p++) begin
      en = 1'b1;
      hist = CFG_W'($urandom_range(2, 33));
      min_live = CFG_W'($urandom_range(0, (hist > 32) ? 32 : int'(hist)));
      lost = ($urandom_range(0, 99) < 70) ? CFG_W'($urandom_range(0, 4))
                                          : CFG_W'($urandom_range(0, 32));
      case (p)
        0: begin en = 1'b0; hist = 6'd11; min_live = 6'd5; lost = 6'd2; end
        1: begin hist = 6'd2; min_live = 6'd1; lost = 6'd0; end
        2: begin hist = 6'd1; min_live = 6'd0; lost = 6'd0; end
        3: begin hist = 6'd0; min_live = 6'd1; lost = 6'd32; end
        4: begin hist = 6'd33; min_live = 6'd32; lost = 6'd32; end
        5: begin hist = 6'd63; min_live = 6'd20; lost = 6'd3; end
        6: begin hist = 6'd4; min_live = 6'd3; lost = 6'd0; end
        7: begin hist = 6'd33; min_live = 6'd0; lost = 6'd0; end
        default: if ($urandom_range(0, 99) < 10) en = 1'b0;
      endcase
      case ($urandom_range(0, 3))
        0: live_pct = 50;
        1: live_pct = 75;
        2: live_pct = 90;
        default: live_pct = 100;
      endcase
      if (p % 4 == 0) live_pct = 100;
      set_config(en, hist, min_live, lost);
      in_gaps_on = (p % 3 != 1);
      out_stall_on = (p % 3 != 2);
      repeat (PHASE_ITEMS) offer_event(random_event(live_pct));
    end

    @(negedge clk);
    item_valid = 1'b0;
    wait_idle();
    repeat (50) @(posedge clk);
    if (tracker.failures() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
